// File: sv/rle8_palette_frame_decoder_assert.svh
// ---------------------------------------------------------------------------
// RLE8 palette frame decoder assertion macros
// Shared assertion forms for the checker; sampled on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef RLE8_PALETTE_FRAME_DECODER_ASSERT_SVH
`define RLE8_PALETTE_FRAME_DECODER_ASSERT_SVH

// same-cycle implication
`define RPFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RPFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/rle8pfd_pkg.sv
// ---------------------------------------------------------------------------
// rle8pfd_pkg
// Shared constants, types and the CRC-32 byte step for the frame decoder.
// ---------------------------------------------------------------------------
package rle8pfd_pkg;

  localparam int unsigned MAX_PIXELS_DEF    = 1048576;
  localparam int unsigned PALETTE_DEPTH_DEF = 256;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // frame status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_INDEX  = 3'd1;
  localparam logic [2:0] ST_ZERO_COUNT = 3'd2;
  localparam logic [2:0] ST_OVERFLOW   = 3'd3;
  localparam logic [2:0] ST_ODD_LENGTH = 3'd4;
  localparam logic [2:0] ST_SIZE       = 3'd5;
  localparam logic [2:0] ST_CRC        = 3'd6;

  // configuration register indexes
  localparam logic [2:0] CFG_CODEC     = 3'd0;
  localparam logic [2:0] CFG_MIRROR    = 3'd1;
  localparam logic [2:0] CFG_PAL_COUNT = 3'd2;
  localparam logic [2:0] CFG_ROW_WIDTH = 3'd3;
  localparam logic [2:0] CFG_FRAME_PIX = 3'd4;
  localparam logic [2:0] CFG_EXP_CRC   = 3'd5;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_BYTE    = 1'b1;

  typedef struct packed {
    logic       accept;
    logic       clr_have;
    logic       set_pend;
    logic       fail;
    logic [2:0] fail_code;
    logic       start_run;
    logic       crc_step;
    logic       seg_emit;
    logic       stat_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic rle;
    logic have;
    logic failed;
    logic last;
    logic zero_cnt;
    logic bad_idx;
    logic ovf_raw;
    logic ovf_rle;
    logic crc_one;
    logic seg_final;
    logic out_free;
  } dp_sts_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] s, input logic [7:0] b);
    logic [31:0] c;
    c = s ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// File: sv/rle8pfd_ctrl.sv
// ---------------------------------------------------------------------------
// rle8pfd_ctrl
// Sequencer: byte checks, CRC pass, segment emission and frame status.
// ---------------------------------------------------------------------------
module rle8pfd_ctrl import rle8pfd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_cmd,
  output logic    in_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_CRC, S_SEG, S_STAT} state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  assign in_stall = in_stall_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.accept = in_valid && !in_stall_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && in_cmd == CMD_BYTE) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.failed) begin
          // rest of a failed frame is dropped
        end else if (!sts.rle) begin
          cmd.clr_have = 1'b1;
          if (sts.bad_idx) begin
            cmd.fail = 1'b1; cmd.fail_code = ST_BAD_INDEX;
          end else if (sts.ovf_raw) begin
            cmd.fail = 1'b1; cmd.fail_code = ST_OVERFLOW;
          end else begin
            cmd.start_run = 1'b1;
          end
        end else if (!sts.have) begin
          if (sts.last) begin
            cmd.fail = 1'b1; cmd.fail_code = ST_ODD_LENGTH;
          end else begin
            cmd.set_pend = 1'b1;
          end
        end else begin
          cmd.clr_have = 1'b1;
          if (sts.zero_cnt) begin
            cmd.fail = 1'b1; cmd.fail_code = ST_ZERO_COUNT;
          end else if (sts.bad_idx) begin
            cmd.fail = 1'b1; cmd.fail_code = ST_BAD_INDEX;
          end else if (sts.ovf_rle) begin
            cmd.fail = 1'b1; cmd.fail_code = ST_OVERFLOW;
          end else begin
            cmd.start_run = 1'b1;
          end
        end
        if (cmd.start_run) state_nxt = S_CRC;
        else               state_nxt = sts.last ? S_STAT : S_IDLE;
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        if (sts.crc_one) state_nxt = S_SEG;
      end
      S_SEG: begin
        if (sts.out_free) begin
          cmd.seg_emit = 1'b1;
          if (sts.seg_final) state_nxt = sts.last ? S_STAT : S_IDLE;
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.stat_emit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

endmodule

// File: sv/rle8pfd_dp.sv
// ---------------------------------------------------------------------------
// rle8pfd_dp
// Datapath: config registers, palette memory, frame state, CRC, output reg.
// ---------------------------------------------------------------------------
module rle8pfd_dp import rle8pfd_pkg::*; #(
  parameter int unsigned MAX_PIXELS    = MAX_PIXELS_DEF,
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_cmd,
  input  logic [7:0]  in_palette_slot,
  input  logic [15:0] in_palette_color,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        out_kind,
  output logic [19:0] out_target_addr,
  output logic [15:0] out_color,
  output logic [7:0]  out_seg_len,
  output logic        out_descending,
  output logic [2:0]  out_status,
  output logic        out_last
);

  localparam int          PAL_AW      = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0]  PAL_DEPTH_V = 9'(PALETTE_DEPTH);
  localparam logic [24:0] MAX_V       = 25'(MAX_PIXELS);

  // configuration
  logic        codec_r, mirror_r;
  logic [8:0]  pal_count_r;
  logic [12:0] row_width_r;
  logic [20:0] frame_pix_r;
  logic [31:0] exp_crc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_r     <= 1'b0;
      mirror_r    <= 1'b0;
      pal_count_r <= 9'd256;
      row_width_r <= 13'd256;
      frame_pix_r <= 21'd65536;
      exp_crc_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CODEC:     codec_r     <= cfg_data[0];
        CFG_MIRROR:    mirror_r    <= cfg_data[0];
        CFG_PAL_COUNT: pal_count_r <= cfg_data[8:0];
        CFG_ROW_WIDTH: row_width_r <= cfg_data[12:0];
        CFG_FRAME_PIX: frame_pix_r <= cfg_data[20:0];
        CFG_EXP_CRC:   exp_crc_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // palette memory, read registered at byte accept
  logic [15:0] pal_mem [PALETTE_DEPTH];
  logic [15:0] pal_rd_r;
  logic [7:0]  byte_r;
  logic        last_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && in_cmd == CMD_PALETTE && {1'b0, in_palette_slot} < PAL_DEPTH_V) begin
      pal_mem[in_palette_slot[PAL_AW-1:0]] <= in_palette_color;
    end
    if (cmd.accept && in_cmd == CMD_BYTE) begin
      pal_rd_r <= pal_mem[in_data_byte[PAL_AW-1:0]];
      byte_r   <= in_data_byte;
      last_r   <= in_last_byte;
    end
  end

  // frame state
  logic [20:0] decoded_r;
  logic [11:0] col_r;
  logic [19:0] base_r;
  logic [31:0] crc_r;
  logic [7:0]  pend_r;
  logic        have_r, failed_r;
  logic [2:0]  code_r;
  logic [7:0]  run_idx_r, run_left_r, crc_left_r;

  logic [8:0]  eff_pal;
  logic [12:0] eff_w;
  logic [20:0] limit;
  logic [7:0]  run_cnt;

  assign eff_pal = (pal_count_r < PAL_DEPTH_V) ? pal_count_r : PAL_DEPTH_V;
  assign limit   = ({4'd0, frame_pix_r} < MAX_V) ? frame_pix_r : MAX_V[20:0];
  assign run_cnt = codec_r ? pend_r : 8'd1;

  always_comb begin
    if (row_width_r < 13'd8)         eff_w = 13'd8;
    else if (row_width_r > 13'd4096) eff_w = 13'd4096;
    else                             eff_w = row_width_r;
  end

  // segment split
  logic [12:0] col_x, c0, avail, nc;
  logic        wrap0, wrap1;
  logic [19:0] b0, b_next, seg_addr;
  logic [7:0]  seg_len;

  always_comb begin
    col_x    = {1'b0, col_r};
    wrap0    = col_x >= eff_w;
    c0       = wrap0 ? 13'd0 : col_x;
    b0       = wrap0 ? base_r + {7'd0, eff_w} : base_r;
    avail    = eff_w - c0;
    seg_len  = ({5'd0, run_left_r} < avail) ? run_left_r : avail[7:0];
    seg_addr = mirror_r ? b0 + {7'd0, eff_w} - 20'd1 - {7'd0, c0} : b0 + {7'd0, c0};
    nc       = c0 + {5'd0, seg_len};
    wrap1    = nc >= eff_w;
    b_next   = b0 + {7'd0, eff_w};
  end

  logic [2:0] end_code;
  always_comb begin
    if (failed_r)                          end_code = code_r;
    else if (decoded_r != limit)           end_code = ST_SIZE;
    else if ((crc_r ^ CRC_INIT) != exp_crc_r) end_code = ST_CRC;
    else                                   end_code = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.stat_emit) begin
      decoded_r <= '0;
      col_r     <= '0;
      base_r    <= '0;
      crc_r     <= CRC_INIT;
      pend_r    <= '0;
      have_r    <= 1'b0;
      failed_r  <= 1'b0;
      code_r    <= ST_OK;
    end else begin
      if (cmd.clr_have) have_r <= 1'b0;
      if (cmd.set_pend) begin
        pend_r <= byte_r;
        have_r <= 1'b1;
      end
      if (cmd.fail) begin
        failed_r <= 1'b1;
        code_r   <= cmd.fail_code;
      end
      if (cmd.start_run) decoded_r <= decoded_r + {13'd0, run_cnt};
      if (cmd.crc_step)  crc_r     <= crc_byte(crc_r, run_idx_r);
      if (cmd.seg_emit) begin
        col_r  <= wrap1 ? 12'd0 : nc[11:0];
        base_r <= wrap1 ? b_next : b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_run) begin
      run_idx_r  <= byte_r;
      run_left_r <= run_cnt;
      crc_left_r <= run_cnt;
    end else begin
      if (cmd.crc_step) crc_left_r <= crc_left_r - 8'd1;
      if (cmd.seg_emit) run_left_r <= run_left_r - seg_len;
    end
  end

  // output register
  logic        out_valid_r, out_free;
  logic        kind_r, desc_r, olast_r;
  logic [19:0] addr_r;
  logic [15:0] color_r;
  logic [7:0]  len_r;
  logic [2:0]  status_r;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.seg_emit || cmd.stat_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_emit) begin
      kind_r   <= 1'b0;
      addr_r   <= seg_addr;
      color_r  <= pal_rd_r;
      len_r    <= seg_len;
      desc_r   <= mirror_r;
      status_r <= ST_OK;
      olast_r  <= 1'b0;
    end else if (cmd.stat_emit) begin
      kind_r   <= 1'b1;
      addr_r   <= '0;
      color_r  <= '0;
      len_r    <= '0;
      desc_r   <= 1'b0;
      status_r <= end_code;
      olast_r  <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_target_addr = addr_r;
  assign out_color       = color_r;
  assign out_seg_len     = len_r;
  assign out_descending  = desc_r;
  assign out_status      = status_r;
  assign out_last        = olast_r;

  always_comb begin
    sts           = '0;
    sts.rle       = codec_r;
    sts.have      = have_r;
    sts.failed    = failed_r;
    sts.last      = last_r;
    sts.zero_cnt  = (pend_r == 8'd0);
    sts.bad_idx   = ({1'b0, byte_r} >= eff_pal);
    sts.ovf_raw   = (decoded_r >= limit);
    sts.ovf_rle   = (({1'b0, decoded_r} + {14'd0, pend_r}) > {1'b0, limit});
    sts.crc_one   = (crc_left_r == 8'd1);
    sts.seg_final = (seg_len == run_left_r);
    sts.out_free  = out_free;
  end

endmodule

// File: sv/rle8_palette_frame_decoder.sv
// ---------------------------------------------------------------------------
// rle8_palette_frame_decoder
// Raw / RLE8 palette-index frame decoder emitting row-bounded pixel runs.
// ---------------------------------------------------------------------------
//  channel | handshake           | carries
//  --------+---------------------+--------------------------------------------
//  in_     | in_valid / in_stall | cmd, palette slot+color, data byte, last
//  out_    | out_valid/out_stall | run segment (addr,color,len,dir) or status
//  cfg_    | cfg_valid/cfg_ready | register index, write data (always ready)
//
// Sequence: a palette write leaves the input free; a frame byte is accepted,
//   then checked; a byte that starts a run of N pixels then steps the CRC once
//   per pixel and emits one row segment per cycle while the output is free;
//   an RLE8 pair also accepts and checks its count byte first.
// Frame end adds the status item.
// Reset: synchronous, active low; palette contents are not cleared.
// out_stall holds the output register and stalls the sequencer in the
//   segment/status states; in_stall is high whenever a byte is in work.
// ---------------------------------------------------------------------------
module rle8_palette_frame_decoder import rle8pfd_pkg::*; #(
  parameter int unsigned MAX_PIXELS    = MAX_PIXELS_DEF,
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_palette_slot,
  input  logic [15:0] in_palette_color,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [19:0] out_target_addr,
  output logic [15:0] out_color,
  output logic [7:0]  out_seg_len,
  output logic        out_descending,
  output logic [2:0]  out_status,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  rle8pfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  rle8pfd_dp #(
    .MAX_PIXELS    (MAX_PIXELS),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .in_palette_slot  (in_palette_slot),
    .in_palette_color (in_palette_color),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_target_addr  (out_target_addr),
    .out_color        (out_color),
    .out_seg_len      (out_seg_len),
    .out_descending   (out_descending),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

// File: sv/rle8pfd_chk.sv
// ---------------------------------------------------------------------------
// rle8pfd_chk
// Port-level checks on the decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "rle8_palette_frame_decoder_assert.svh"

module rle8pfd_chk import rle8pfd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_cmd,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [19:0] out_target_addr,
  input logic [15:0] out_color,
  input logic [7:0]  out_seg_len,
  input logic        out_descending,
  input logic [2:0]  out_status,
  input logic        out_last
);

  `RPFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_target_addr) && $stable(out_color) && $stable(out_kind),
    "stalled item changed")
  `RPFD_ASSERT_NOW(a_seg_shape, out_valid && !out_kind,
    out_seg_len != 8'd0 && out_status == ST_OK && !out_last,
    "bad segment fields")
  `RPFD_ASSERT_NOW(a_stat_shape, out_valid && out_kind,
    out_last && out_seg_len == 8'd0 && out_status <= ST_CRC && !out_descending,
    "bad status fields")
  `RPFD_ASSERT_NEXT(a_pal_nostall, in_valid && !in_stall && in_cmd == CMD_PALETTE,
    !in_stall, "palette write blocked input")

endmodule

bind rle8_palette_frame_decoder rle8pfd_chk u_rle8pfd_chk (.*);

// File: tb/frame_decoder_checker.sv
// ---------------------------------------------------------------------------
// frame_decoder_checker
// Watches the config, byte and result channels of the frame decoder, keeps
// its own decode state and compares every result item with the prediction.
// ---------------------------------------------------------------------------
module frame_decoder_checker import rle8pfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_palette_slot,
  input  logic [15:0] in_palette_color,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic [19:0] out_target_addr,
  input  logic [15:0] out_color,
  input  logic [7:0]  out_seg_len,
  input  logic        out_descending,
  input  logic [2:0]  out_status,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic        kind;
    logic [19:0] addr;
    logic [15:0] color;
    logic [7:0]  len;
    logic        desc;
    logic [2:0]  status;
    logic        last;
  } pixel_run_t;

  pixel_run_t runs_due[$];

  logic        codec_rle, mirror_on;
  logic [8:0]  pal_count;
  logic [12:0] row_w;
  logic [20:0] frame_pix;
  logic [31:0] crc_want;
  logic [15:0] colors [256];

  int unsigned npix, col, base;
  logic [31:0] crc;
  logic [7:0]  held_count;
  logic        have_count, failed;
  logic [2:0]  fail_code;

  function automatic logic [31:0] crc_update(input logic [31:0] s, input logic [7:0] b);
    logic [31:0] c;
    c = s ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    return c;
  endfunction

  function automatic int unsigned width_used();
    if (row_w < 8) return 8;
    if (row_w > 4096) return 4096;
    return row_w;
  endfunction

  function automatic int unsigned pixel_limit();
    return (frame_pix < MAX_PIXELS_DEF) ? frame_pix : MAX_PIXELS_DEF;
  endfunction

  function automatic int unsigned pal_used();
    return (pal_count < 256) ? pal_count : 256;
  endfunction

  task automatic clear_frame();
    npix = 0; col = 0; base = 0; crc = CRC_INIT;
    held_count = 0; have_count = 0; failed = 0; fail_code = ST_OK;
  endtask

  task automatic mark_fail(input logic [2:0] code);
    if (!failed) begin
      failed = 1; fail_code = code;
    end
  endtask

  task automatic decode_run(input logic [7:0] idx, input int unsigned count);
    pixel_run_t r;
    int unsigned left, w, seg;
    left = count;
    repeat (count) crc = crc_update(crc, idx);
    npix += count;
    while (left > 0) begin
      w = width_used();
      if (col >= w) begin
        col = 0; base = (base + w) & 20'hFFFFF;
      end
      seg = (left < w - col) ? left : w - col;
      r = '0;
      r.addr  = 20'(mirror_on ? (base + w - 1 - col) : (base + col));
      r.color = colors[idx];
      r.len   = 8'(seg);
      r.desc  = mirror_on;
      runs_due.push_back(r);
      col += seg;
      left -= seg;
      if (col >= w) begin
        col = 0; base = (base + w) & 20'hFFFFF;
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    pixel_run_t st;
    if (!failed) begin
      if (!codec_rle) begin
        have_count = 0;
        if (b >= pal_used()) mark_fail(ST_BAD_INDEX);
        else if (npix >= pixel_limit()) mark_fail(ST_OVERFLOW);
        else decode_run(b, 1);
      end else if (!have_count) begin
        if (last) mark_fail(ST_ODD_LENGTH);
        else begin
          held_count = b; have_count = 1;
        end
      end else begin
        have_count = 0;
        if (held_count == 0) mark_fail(ST_ZERO_COUNT);
        else if (b >= pal_used()) mark_fail(ST_BAD_INDEX);
        else if (npix + held_count > pixel_limit()) mark_fail(ST_OVERFLOW);
        else decode_run(b, held_count);
      end
    end
    if (last) begin
      if (!failed) begin
        if (npix != pixel_limit()) mark_fail(ST_SIZE);
        else if ((crc ^ CRC_INIT) != crc_want) mark_fail(ST_CRC);
      end
      st = '0;
      st.kind = 1; st.status = fail_code; st.last = 1;
      runs_due.push_back(st);
      clear_frame();
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      errors++;
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    pixel_run_t w;
    if (!rst_n) begin
      codec_rle = 0; mirror_on = 0; pal_count = 256; row_w = 256;
      frame_pix = 65536; crc_want = 0;
      runs_due.delete();
      clear_frame();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CODEC:     codec_rle = cfg_data[0];
          CFG_MIRROR:    mirror_on = cfg_data[0];
          CFG_PAL_COUNT: pal_count = cfg_data[8:0];
          CFG_ROW_WIDTH: row_w     = cfg_data[12:0];
          CFG_FRAME_PIX: frame_pix = cfg_data[20:0];
          CFG_EXP_CRC:   crc_want  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_cmd == CMD_PALETTE) colors[in_palette_slot] = in_palette_color;
        else take_byte(in_data_byte, in_last_byte);
      end
      if (out_valid && !out_stall) begin
        if (runs_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0b status %0d",
                   $realtime, out_kind, out_status);
          errors++;
        end else begin
          w = runs_due.pop_front();
          compare_field("kind", w.kind, out_kind);
          compare_field("target_addr", w.addr, out_target_addr);
          compare_field("color", w.color, out_color);
          compare_field("seg_len", w.len, out_seg_len);
          compare_field("descending", w.desc, out_descending);
          compare_field("status", w.status, out_status);
          compare_field("last", w.last, out_last);
        end
      end
    end
    pending = runs_due.size();
  end

endmodule

// File: tb/rle8_palette_frame_decoder_tb.sv
// ---------------------------------------------------------------------------
// rle8_palette_frame_decoder_tb
// Drives whole frames (raw and RLE8, mirrored or not, with injected faults)
// into the decoder under random idling and one long output hold-off; the
// checker beside the block predicts and compares every result item.
// ---------------------------------------------------------------------------
module rle8_palette_frame_decoder_tb;
  import rle8pfd_pkg::*;

  typedef enum int {FLT_NONE, FLT_BAD_INDEX, FLT_ZERO, FLT_OVERFLOW, FLT_ODD, FLT_CRC}
    frame_fault_e;

  localparam int STALL_LIMIT = 6000;   // cycles with no handshake at all
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int PAL_FILL    = 16;     // palette slots loaded up front
  localparam int ITEM_GOAL   = 200;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0, in_cmd = 0, in_last_byte = 0;
  logic [7:0]  in_palette_slot = 0, in_data_byte = 0;
  logic [15:0] in_palette_color = 0;
  logic        in_stall;
  logic        out_valid, out_kind, out_descending, out_last;
  logic        out_stall = 0;
  logic [19:0] out_target_addr;
  logic [15:0] out_color;
  logic [7:0]  out_seg_len;
  logic [2:0]  out_status;
  logic        cfg_valid = 0, cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;

  int errors, pending;
  int send_idle_pct = 34, recv_stall_pct = 73;
  int hold_req = 0, hold_taken = 0, hold_left = 0;
  int items_sent = 0, frames_sent = 0, results_seen = 0, quiet = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  rle8_palette_frame_decoder dut (.*);

  frame_decoder_checker chk (.*);

  // receiver: random stall, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_taken != hold_req) begin
      hold_taken <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on handshake-free stretches
  always @(posedge clk) begin
    if (out_valid && !out_stall) results_seen++;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("rle8_palette_frame_decoder_tb: errors");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] slot, input logic [15:0] pcolor,
                           input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_cmd <= cmd; in_palette_slot <= slot;
    in_palette_color <= pcolor; in_data_byte <= b; in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);   // block may still be finishing a byte
  endtask

  task automatic write_regs(input logic rle, mir, input logic [8:0] pal,
                            input logic [12:0] rw, input logic [20:0] fpix,
                            input logic [31:0] crc);
    logic [31:0] vals [6];
    vals[CFG_CODEC] = {31'd0, rle};  vals[CFG_MIRROR] = {31'd0, mir};
    vals[CFG_PAL_COUNT] = {23'd0, pal}; vals[CFG_ROW_WIDTH] = {19'd0, rw};
    vals[CFG_FRAME_PIX] = {11'd0, fpix}; vals[CFG_EXP_CRC] = crc;
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1; cfg_index <= 3'(i); cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // plans npix pixels, programs frame_pixels = fcfg, applies one fault;
  // valid pixels only use palette slots that were loaded
  task automatic run_frame(input logic rle, mir, input int pal, rw, npix, fcfg,
                           input int maxrun, input frame_fault_e fault);
    logic [7:0]  stream[$];
    logic [31:0] crc;
    int left, cnt, idx, pal_eff, idx_top, k;
    pal_eff = (pal > 256) ? 256 : pal;
    idx_top = (pal_eff < PAL_FILL) ? pal_eff : PAL_FILL;
    crc = CRC_INIT;
    left = npix;
    while (left > 0) begin
      cnt = rle ? $urandom_range(1, (left < maxrun) ? left : maxrun) : 1;
      idx = $urandom_range(0, idx_top - 1);
      if (rle) stream.push_back(8'(cnt));
      stream.push_back(8'(idx));
      repeat (cnt) crc = chk.crc_update(crc, 8'(idx));
      left -= cnt;
    end
    k = rle ? 2 * $urandom_range(0, stream.size() / 2 - 1) : $urandom_range(0, stream.size() - 1);
    case (fault)
      FLT_BAD_INDEX: stream[rle ? k + 1 : k] = 8'($urandom_range(pal_eff, 255));
      FLT_ZERO:      stream[k] = 8'd0;
      FLT_OVERFLOW: begin
        if (rle) stream.push_back(8'($urandom_range(1, 255)));
        stream.push_back(8'd0);
      end
      FLT_ODD:       stream.push_back(8'($urandom_range(0, PAL_FILL - 1)));
      FLT_CRC:       crc ^= 32'h1 << $urandom_range(0, 31);
      default: ;
    endcase
    write_regs(rle, mir, 9'(pal), 13'(rw), 21'(fcfg), crc ^ CRC_INIT);
    foreach (stream[i]) begin
      if ($urandom_range(99) < 8)   // palette rewrite mid-frame
        send_item(CMD_PALETTE, 8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
      send_item(CMD_BYTE, 8'($urandom), 16'($urandom), stream[i], i == stream.size() - 1);
    end
    stop_sending();
    frames_sent++;
    wait_drained();
  endtask

  initial begin
    frame_fault_e f;
    int rw_pick, pal, np;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // load the low palette slots; every valid index stays below PAL_FILL
    for (int s = 0; s < PAL_FILL; s++)
      send_item(CMD_PALETTE, 8'(s), 16'($urandom), 8'($urandom), 1'($urandom));
    stop_sending();

    // long hold: one segment parks in the output, the next byte backs up
    hold_req++;
    run_frame(0, 0, 16,  8,    12, 12,      1,   FLT_NONE);

    // directed: extremes, each status, mirroring, width saturation
    run_frame(0, 0, 2,   8,    1,  1,       1,   FLT_NONE);
    run_frame(0, 0, 2,   8,    3,  3,       1,   FLT_BAD_INDEX);
    run_frame(1, 0, 256, 8,    10, 10,      255, FLT_ZERO);
    run_frame(1, 1, 256, 0,    20, 20,      255, FLT_NONE);
    run_frame(1, 0, 200, 8,    5,  5,       255, FLT_BAD_INDEX);
    run_frame(1, 0, 256, 8,    5,  5,       255, FLT_ODD);
    run_frame(1, 0, 256, 8,    5,  5,       255, FLT_OVERFLOW);
    run_frame(0, 1, 511, 8191, 4,  4,       1,   FLT_CRC);
    run_frame(1, 1, 256, 4096, 255, 255,    255, FLT_NONE);
    run_frame(0, 0, 256, 9,    3,  2097151, 1,   FLT_NONE);
    run_frame(0, 0, 256, 9,    2,  0,       1,   FLT_NONE);

    // random frames; idling changes with progress
    while (items_sent < ITEM_GOAL) begin
      if (items_sent > 150) begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end else if (items_sent > 100) begin
        send_idle_pct = 73; recv_stall_pct = 34;
      end
      rw_pick = $urandom_range(0, 9);
      pal = ($urandom_range(0, 9) == 0) ? 511 : $urandom_range(2, 256);
      np = $urandom_range(1, 40);
      case ($urandom_range(0, 19))
        0: f = FLT_ZERO;
        1: f = FLT_ODD;
        2: f = FLT_OVERFLOW;
        3: f = FLT_CRC;
        4: f = (pal < 256) ? FLT_BAD_INDEX : FLT_NONE;
        default: f = FLT_NONE;
      endcase
      run_frame(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pal,
                (rw_pick == 0) ? $urandom_range(0, 7) :
                (rw_pick == 1) ? 4096 : $urandom_range(8, 40),
                np, ($urandom_range(0, 14) == 0) ? np + $urandom_range(1, 3) : np,
                $urandom_range(1, 255), f);
    end

    $display("frames %0d, items %0d, results %0d: raw and RLE8, mirrored rows,",
             frames_sent, items_sent, results_seen);
    $display("every status code, width saturation and a long output hold-off");
    if (errors == 0) begin
      $display("rle8_palette_frame_decoder_tb: clean");
    end else begin
      $display("rle8_palette_frame_decoder_tb: errors");
    end
    $finish;
  end

endmodule
